@@ design/fula_pkg.sv @@
`timescale 1ns / 1ps
// fula_pkg: shared codes, field widths and types for the free-list allocator
// used by every module of the fixed_unit_free_list_allocator_core block
package fula_pkg;

  localparam int UBYTES_W    = 13;
  localparam int UTOTAL_W    = 9;
  localparam int SPAN_W      = UBYTES_W + UTOTAL_W;
  localparam int CFG_INDEX_W = 2;

  localparam logic [UBYTES_W-1:0] UBYTES_RST = 13'd64;
  localparam logic [UTOTAL_W-1:0] UTOTAL_RST = 9'd0;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_SIZE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_COUNT = 2'd2;

  // item modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_FILL = 4'b1000
  } state_t;

  // strobes from the sequencer to the stack memory
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

  // count fields also carry the unit total less the depth, so never below its width
  function automatic int CNT_WL(int units);
    int w;
    w = $clog2(units + 1);
    return (w > UTOTAL_W) ? w : UTOTAL_W;
  endfunction

  // write data as wide as the widest register
  function automatic int DATA_WL(int addr_bits);
    return (addr_bits > UBYTES_W) ? addr_bits : UBYTES_W;
  endfunction

endpackage

@@ design/fula_cfg.sv @@
`timescale 1ns / 1ps
// fula_cfg: configuration registers and the registered pool span
// depends on fula_pkg
module fula_cfg
  import fula_pkg::*;
#(
  parameter int ADDR_BITS = 32,
  parameter int DATA_W    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  output logic [ADDR_BITS-1:0]   pool_base,
  output logic [UBYTES_W-1:0]    unit_bytes,
  output logic [UTOTAL_W-1:0]    unit_total,
  output logic [SPAN_W-1:0]      span
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      unit_bytes <= UBYTES_RST;
      unit_total <= UTOTAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POOL_BASE:  pool_base  <= cfg_data[ADDR_BITS-1:0];
        REG_UNIT_SIZE:  unit_bytes <= cfg_data[UBYTES_W-1:0];
        REG_UNIT_COUNT: unit_total <= cfg_data[UTOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // pool size in bytes, registered from unit_bytes and unit_total
  always_ff @(posedge clk) begin
    span <= SPAN_W'(unit_bytes) * SPAN_W'(unit_total);
  end

endmodule

@@ design/fula_stack_mem.sv @@
`timescale 1ns / 1ps
// fula_stack_mem: single-port stack storage with registered read data
// depends on fula_pkg
module fula_stack_mem
  import fula_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int IW    = 8
) (
  input  logic             clk,
  input  mem_cmd_t         cmd,
  input  logic [IW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end
    if (cmd.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/fula_ctrl.sv @@
`timescale 1ns / 1ps
// fula_ctrl: item sequencer, stack pointer, restart fill and result register
// depends on fula_pkg
module fula_ctrl
  import fula_pkg::*;
#(
  parameter int MAX_UNITS = 256,
  parameter int ADDR_BITS = 32,
  parameter int IW        = 8,
  parameter int CW        = 9,
  parameter int CNT_W     = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [ADDR_BITS-1:0]  unit_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [ADDR_BITS-1:0]  given_address,
  output logic [CNT_W-1:0]      free_units,
  output logic [CNT_W-1:0]      used_units,
  output logic                  none_free,
  input  logic [ADDR_BITS-1:0]  pool_base,
  input  logic [UBYTES_W-1:0]   unit_bytes,
  input  logic [UTOTAL_W-1:0]   unit_total,
  input  logic [SPAN_W-1:0]     span,
  output mem_cmd_t              cmd,
  output logic [IW-1:0]         mem_addr,
  output logic [ADDR_BITS-1:0]  mem_wdata,
  input  logic [ADDR_BITS-1:0]  mem_rdata
);

  localparam int CMP_W = (ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W;

  state_t               state, state_next;
  logic [CW-1:0]        depth, depth_next;
  logic [CNT_W-1:0]     fill_idx, fill_idx_next;
  logic [ADDR_BITS-1:0] fill_addr, fill_addr_next;
  logic [1:0]           mode_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic                 accept;
  logic                 out_free;
  logic                 produce;
  logic [1:0]           res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic [CW-1:0]        res_depth;
  logic [CW-1:0]        depth_dec;
  logic [ADDR_BITS-1:0] offset;
  logic                 outside;
  logic                 full;
  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     uc_ext;
  logic [CNT_W-1:0]     rd_ext;
  logic [CNT_W-1:0]     used_calc;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign depth_dec = depth - CW'(1);
  assign offset    = addr_q - pool_base;
  assign outside   = CMP_W'(offset) >= CMP_W'(span);
  assign full      = depth >= CW'(MAX_UNITS);

  // restart pushes at most the stack capacity
  assign uc_ext     = CNT_W'(unit_total);
  assign fill_count = (uc_ext > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : uc_ext;

  always_comb begin
    state_next     = state;
    depth_next     = depth;
    fill_idx_next  = fill_idx;
    fill_addr_next = fill_addr;
    cmd            = '0;
    mem_addr       = depth[IW-1:0];
    mem_wdata      = addr_q;
    produce        = 1'b0;
    res_status     = ST_OK;
    res_addr       = '0;
    res_depth      = depth;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_q)
          MODE_ALLOC: begin
            if (depth == '0) begin
              if (out_free) begin
                produce    = 1'b1;
                res_status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              // pop: read the top entry, data shows up next cycle
              cmd.re     = 1'b1;
              mem_addr   = depth_dec[IW-1:0];
              depth_next = depth_dec;
              state_next = S_READ;
            end
          end
          MODE_FREE: begin
            if (out_free) begin
              produce    = 1'b1;
              state_next = S_IDLE;
              if (outside) begin
                res_status = ST_RANGE;
              end else if (full) begin
                res_status = ST_OVERFLOW;
              end else begin
                cmd.we     = 1'b1;
                depth_next = depth + CW'(1);
                res_depth  = depth + CW'(1);
              end
            end
          end
          MODE_RESTART: begin
            fill_idx_next  = '0;
            fill_addr_next = pool_base;
            state_next     = S_FILL;
          end
          default: begin
            if (out_free) begin
              produce    = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (out_free) begin
          produce    = 1'b1;
          res_addr   = mem_rdata;
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        if (fill_idx == fill_count) begin
          if (out_free) begin
            produce    = 1'b1;
            depth_next = fill_count[CW-1:0];
            res_depth  = fill_count[CW-1:0];
            state_next = S_IDLE;
          end
        end else begin
          cmd.we         = 1'b1;
          mem_addr       = fill_idx[IW-1:0];
          mem_wdata      = fill_addr;
          fill_idx_next  = fill_idx + CNT_W'(1);
          fill_addr_next = fill_addr + ADDR_BITS'(unit_bytes);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_ext    = CNT_W'(res_depth);
  assign used_calc = (uc_ext > rd_ext) ? (uc_ext - rd_ext) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_idx  <= fill_idx_next;
    fill_addr <= fill_addr_next;
    if (accept) begin
      mode_q <= mode;
      addr_q <= unit_address;
    end
    if (produce) begin
      status        <= res_status;
      given_address <= res_addr;
      free_units    <= rd_ext;
      used_units    <= used_calc;
      none_free     <= (res_depth == '0);
    end
  end

endmodule

@@ design/fixed_unit_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
// fixed_unit_free_list_allocator_core: top level of the free-list allocator
// depends on fula_pkg, fula_cfg, fula_stack_mem, fula_ctrl
//
//   port group   handshake               payload
//   ----------   ---------------------   ----------------------------------------
//   in           in_valid / in_stall     mode, unit_address
//   out          out_valid / out_stall   status, given_address, free_units,
//                                        used_units, none_free
//   cfg          cfg_write               cfg_index, cfg_data
//
// free and failed alloc go through S_IDLE and S_EXEC, a successful alloc also
// through S_READ: the one read port of the stack memory gives the popped entry registered.
// restart writes min(unit_total, MAX_UNITS) entries in S_FILL, one entry a cycle.
// one item is worked on at a time; the result register frees the input side, so
// a new beat is taken while the last result waits on out_stall.
// reset (rst, synchronous) empties the stack; the memory needs no clearing pass.
module fixed_unit_free_list_allocator_core
  import fula_pkg::*;
#(
  parameter int MAX_UNITS = 256,
  parameter int ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [ADDR_BITS-1:0]                unit_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [ADDR_BITS-1:0]                given_address,
  output logic [CNT_WL(MAX_UNITS)-1:0]        free_units,
  output logic [CNT_WL(MAX_UNITS)-1:0]        used_units,
  output logic                                none_free,
  input  logic                                cfg_write,
  input  logic [CFG_INDEX_W-1:0]              cfg_index,
  input  logic [DATA_WL(ADDR_BITS)-1:0]       cfg_data
);

  localparam int IW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CW    = $clog2(MAX_UNITS + 1);
  localparam int CNT_W = CNT_WL(MAX_UNITS);
  localparam int DATA_W = DATA_WL(ADDR_BITS);

  logic [ADDR_BITS-1:0]  pool_base;
  logic [UBYTES_W-1:0]   unit_bytes;
  logic [UTOTAL_W-1:0]   unit_total;
  logic [SPAN_W-1:0]     span;
  mem_cmd_t              cmd;
  logic [IW-1:0]         mem_addr;
  logic [ADDR_BITS-1:0]  mem_wdata;
  logic [ADDR_BITS-1:0]  mem_rdata;

  fula_cfg #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_W    (DATA_W)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pool_base  (pool_base),
    .unit_bytes (unit_bytes),
    .unit_total (unit_total),
    .span       (span)
  );

  fula_stack_mem #(
    .DEPTH (MAX_UNITS),
    .WIDTH (ADDR_BITS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .cmd   (cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fula_ctrl #(
    .MAX_UNITS (MAX_UNITS),
    .ADDR_BITS (ADDR_BITS),
    .IW        (IW),
    .CW        (CW),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .unit_address  (unit_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .given_address (given_address),
    .free_units    (free_units),
    .used_units    (used_units),
    .none_free     (none_free),
    .pool_base     (pool_base),
    .unit_bytes    (unit_bytes),
    .unit_total    (unit_total),
    .span          (span),
    .cmd           (cmd),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

endmodule

@@ design/fula_checker.sv @@
`timescale 1ns / 1ps
// fula_checker: port-level checks on the allocator top level, bound in below
// depends on fula_pkg and fixed_unit_free_list_allocator_core
module fula_checker
  import fula_pkg::*;
#(
  parameter int MAX_UNITS = 256,
  parameter int ADDR_BITS = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   status,
  input logic [ADDR_BITS-1:0]         given_address,
  input logic [CNT_WL(MAX_UNITS)-1:0] free_units,
  input logic                         none_free
);

  localparam int CNT_W = CNT_WL(MAX_UNITS);

  // one item at a time: a taken beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (none_free == (free_units == '0)))
    else $error("none_free disagrees with free_units");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_units <= CNT_W'(MAX_UNITS)))
    else $error("free count above capacity");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (given_address != '0) |-> (status == ST_OK))
    else $error("address given with a failing status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

endmodule

bind fixed_unit_free_list_allocator_core fula_checker #(
  .MAX_UNITS (MAX_UNITS),
  .ADDR_BITS (ADDR_BITS)
) u_fula_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .given_address (given_address),
  .free_units    (free_units),
  .none_free     (none_free)
);
